FILE: rtl/core/lch_pkg.sv
// Shared types, sizes and helper functions for the Lab channel histogram.
// Used by lab_channel_histogram_top; depends on nothing else.
`default_nettype none

package lch_pkg;

  // Histogram geometry.
  localparam int BIN_COUNT  = 256;
  localparam int COUNT_BITS = 24;
  localparam int CHANNELS   = 3;

  localparam int BIN_BITS   = $clog2(BIN_COUNT);
  localparam int MARGIN_W   = $clog2(BIN_COUNT + 1);
  localparam int CH_BITS    = 2;

  // Fixed widths of the transfer fields.
  localparam int VALUE_W        = 8;
  localparam int COUNT_FIELD_W  = 24;
  localparam int MARGIN_FIELD_W = 9;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_MARGIN = 2'd3
  } mode_t;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [BIN_BITS-1:0]   bin_t;

  // Map a plane byte to a bin; bytes beyond the last bin land in the last bin.
  function automatic bin_t bin_of(input logic [VALUE_W-1:0] v);
    if ({1'b0, v} >= (VALUE_W+1)'(BIN_COUNT)) begin
      return BIN_BITS'(BIN_COUNT - 1);
    end
    return BIN_BITS'(v);
  endfunction

  // Saturating increment of one bin counter.
  function automatic count_t sat_inc(input count_t c);
    if (c == '1) begin
      return c;
    end
    return c + COUNT_BITS'(1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lab_channel_histogram_top.sv
// Top level of the Lab channel histogram: three bin RAMs, the pixel
// read-modify-write pipeline and the clear / margin scan sequencer.
// Depends on lch_pkg and lch_ram.
//
//   channel  direction  handshake           payload
//   input    in         in_valid/in_stall   mode, l_value, a_value, b_value,
//                                           channel, bin_index
//   output   out        out_valid/out_stall bin_count, leading_empty,
//                                           trailing_empty
//
// Pixel adds and bin reads take one transfer per cycle while the output does
// not stall; each is registered in stage one with the bin RAM read, then in
// the output register. A clear walks every bin, one per cycle.
// A margin query reads one channel bin by bin.
// After reset the same clearing pass runs over every bin before the
// first transfer is taken. Output stalls hold the pipeline in place.
`default_nettype none

module lab_channel_histogram_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   mode,
  input  wire logic [lch_pkg::VALUE_W-1:0]  l_value,
  input  wire logic [lch_pkg::VALUE_W-1:0]  a_value,
  input  wire logic [lch_pkg::VALUE_W-1:0]  b_value,
  input  wire logic [lch_pkg::CH_BITS-1:0]  channel,
  input  wire logic [lch_pkg::VALUE_W-1:0]  bin_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [lch_pkg::COUNT_FIELD_W-1:0]  bin_count,
  output logic [lch_pkg::MARGIN_FIELD_W-1:0] leading_empty,
  output logic [lch_pkg::MARGIN_FIELD_W-1:0] trailing_empty
);

  import lch_pkg::*;

  typedef enum logic [3:0] {
    S_RUN   = 4'b0001,
    S_CLEAR = 4'b0010,
    S_SCAN  = 4'b0100,
    S_REPLY = 4'b1000
  } state_t;

  state_t state, state_next;

  // Bin RAM ports, one RAM for each channel.
  logic   ram_we    [CHANNELS];
  bin_t   ram_waddr [CHANNELS];
  count_t ram_wdata [CHANNELS];
  bin_t   ram_raddr [CHANNELS];
  count_t ram_rdata [CHANNELS];

  // Stage one: the item whose bin reads are coming back from the RAMs.
  logic   s1_valid;
  mode_t  s1_mode;
  logic [CH_BITS-1:0] s1_ch;
  logic   s1_idx_ok;
  bin_t   s1_addr [CHANNELS];

  // Last write of each RAM, used to forward a value written in the same
  // cycle that the next read of that bin was issued.
  logic   fw_valid [CHANNELS];
  bin_t   fw_addr  [CHANNELS];
  count_t fw_data  [CHANNELS];
  count_t cur      [CHANNELS];

  // Sequencer state for clear and margin scan.
  logic [BIN_BITS:0]  seq_cnt;
  logic               clr_reply;
  logic               rep_scan;
  logic [CH_BITS-1:0] scan_ch;
  logic               scan_q_valid;
  bin_t               scan_q_addr;
  logic               found;
  bin_t               first_bin;
  bin_t               last_bin;
  count_t             scan_data;
  logic               scan_issue;

  mode_t in_mode;
  logic  is_seq;
  logic  in_acc;
  logic  in_acc_pipe;
  logic  out_free;
  logic  s1_move;
  logic  reply_load;
  bin_t  new_addr [CHANNELS];
  logic [MARGIN_W-1:0] lead_calc;
  logic [MARGIN_W-1:0] trail_calc;

  assign in_mode  = mode_t'(mode);
  // Clears and real margin queries run on the sequencer; everything else
  // flows through the pipeline.
  assign is_seq   = (in_mode == MODE_CLEAR) ||
                    ((in_mode == MODE_MARGIN) && (channel < CH_BITS'(CHANNELS)));
  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;

  // The sequencer needs an empty pipeline so its RAM accesses stand alone.
  assign in_stall = (state != S_RUN) || (s1_valid && !out_free) ||
                    (is_seq && s1_valid);
  assign in_acc      = in_valid && !in_stall;
  assign in_acc_pipe = in_acc && !is_seq;

  assign new_addr[0] = (in_mode == MODE_ADD) ? bin_of(l_value) : BIN_BITS'(bin_index);
  assign new_addr[1] = (in_mode == MODE_ADD) ? bin_of(a_value) : BIN_BITS'(bin_index);
  assign new_addr[2] = (in_mode == MODE_ADD) ? bin_of(b_value) : BIN_BITS'(bin_index);

  assign scan_issue = (state == S_SCAN) && (seq_cnt < (BIN_BITS+1)'(BIN_COUNT));
  assign reply_load = (state == S_REPLY) && out_free;

  // RAMs and their port steering.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    lch_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BIN_COUNT)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[c]),
      .waddr (ram_waddr[c]),
      .wdata (ram_wdata[c]),
      .raddr (ram_raddr[c]),
      .rdata (ram_rdata[c])
    );

    assign cur[c] = (fw_valid[c] && (fw_addr[c] == s1_addr[c])) ? fw_data[c]
                                                                 : ram_rdata[c];

    always_comb begin
      ram_we[c]    = 1'b0;
      ram_waddr[c] = s1_addr[c];
      ram_wdata[c] = sat_inc(cur[c]);
      ram_raddr[c] = in_acc_pipe ? new_addr[c] : s1_addr[c];
      if (state == S_CLEAR) begin
        ram_we[c]    = 1'b1;
        ram_waddr[c] = seq_cnt[BIN_BITS-1:0];
        ram_wdata[c] = '0;
      end else if (state == S_SCAN) begin
        ram_raddr[c] = seq_cnt[BIN_BITS-1:0];
      end else if (state == S_RUN) begin
        ram_we[c] = s1_move && (s1_mode == MODE_ADD);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        fw_valid[c] <= 1'b0;
      end else begin
        fw_valid[c] <= ram_we[c];
      end
      fw_addr[c] <= ram_waddr[c];
      fw_data[c] <= ram_wdata[c];
    end
  end

  // Stage one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc_pipe) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (in_acc_pipe) begin
      s1_mode   <= in_mode;
      s1_ch     <= channel;
      s1_idx_ok <= ({1'b0, bin_index} < (VALUE_W+1)'(BIN_COUNT));
      for (int c = 0; c < CHANNELS; c++) begin
        s1_addr[c] <= new_addr[c];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (in_acc && is_seq) begin
          state_next = (in_mode == MODE_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_CLEAR: begin
        if (seq_cnt[BIN_BITS-1:0] == BIN_BITS'(BIN_COUNT - 1)) begin
          state_next = clr_reply ? S_REPLY : S_RUN;
        end
      end
      S_SCAN: begin
        if (scan_q_valid && (scan_q_addr == BIN_BITS'(BIN_COUNT - 1))) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

  assign scan_data = ram_rdata[scan_ch];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      seq_cnt      <= '0;
      clr_reply    <= 1'b0;
      scan_q_valid <= 1'b0;
    end else begin
      state        <= state_next;
      scan_q_valid <= scan_issue;
      if (state == S_RUN) begin
        seq_cnt <= '0;
      end else if ((state == S_CLEAR) || scan_issue) begin
        seq_cnt <= seq_cnt + (BIN_BITS+1)'(1);
      end
      if (in_acc && is_seq) begin
        clr_reply <= 1'b1;
      end
    end
    scan_q_addr <= seq_cnt[BIN_BITS-1:0];
    if (in_acc && is_seq) begin
      scan_ch  <= channel;
      rep_scan <= (in_mode == MODE_MARGIN);
      found    <= 1'b0;
    end else if (scan_q_valid && (scan_data != '0)) begin
      found    <= 1'b1;
      last_bin <= scan_q_addr;
      if (!found) begin
        first_bin <= scan_q_addr;
      end
    end
  end

  // An empty channel reports BIN_COUNT at both ends.
  assign lead_calc  = found ? MARGIN_W'(first_bin) : MARGIN_W'(BIN_COUNT);
  assign trail_calc = found ? MARGIN_W'(BIN_COUNT - 1) - MARGIN_W'(last_bin)
                            : MARGIN_W'(BIN_COUNT);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move || reply_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      bin_count      <= '0;
      leading_empty  <= '0;
      trailing_empty <= '0;
      if ((s1_mode == MODE_READ) && (s1_ch < CH_BITS'(CHANNELS)) && s1_idx_ok) begin
        bin_count <= COUNT_FIELD_W'(cur[s1_ch]);
      end
    end else if (reply_load) begin
      bin_count      <= '0;
      leading_empty  <= rep_scan ? MARGIN_FIELD_W'(lead_calc) : '0;
      trailing_empty <= rep_scan ? MARGIN_FIELD_W'(trail_calc) : '0;
    end
  end

  // The pipeline is empty whenever the sequencer owns the RAMs.
  a_seq_pipe_empty : assert property (@(posedge clk) disable iff (rst)
    (state != S_RUN) |-> !s1_valid)
    else $error("pipeline item present while sequencer active");

  // A margin scan never writes the bin RAMs.
  a_scan_no_write : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ram_we[0] && !ram_we[1] && !ram_we[2])
    else $error("bin RAM written during margin scan");

  // A held stage-one item keeps its bin addresses so the RAM re-reads them.
  a_s1_hold : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_addr[0]) &&
                             $stable(s1_addr[1]) && $stable(s1_addr[2]))
    else $error("stalled stage-one item changed");

  // Reset always starts the clearing pass.
  a_reset_clear : assert property (@(posedge clk)
    $fell(rst) |-> (state == S_CLEAR) && (seq_cnt == '0))
    else $error("clearing pass did not start after reset");

  // Output loads from the pipeline and from the sequencer never collide.
  a_one_source : assert property (@(posedge clk) disable iff (rst)
    !(s1_move && reply_load))
    else $error("two result sources in one cycle");

endmodule

`default_nettype wire

FILE: rtl/core/lch_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stands alone; no package dependency.
`default_nettype none

module lch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
